// ===== rtl/core/psb_pkg.sv =====
// Package for the parameter smoother bank: constants, mode codes, row and
// control/status types, and the clamp helper. No dependencies.
package psb_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 64;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // item modes
  localparam logic [2:0] MODE_DEFINE   = 3'd0;
  localparam logic [2:0] MODE_SET      = 3'd1;
  localparam logic [2:0] MODE_SET_NORM = 3'd2;
  localparam logic [2:0] MODE_SNAP     = 3'd3;
  localparam logic [2:0] MODE_SNAP_ALL = 3'd4;
  localparam logic [2:0] MODE_ADVANCE  = 3'd5;
  localparam logic [2:0] MODE_READ     = 3'd6;

  // one entry of the bank as stored in RAM
  typedef struct packed {
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic [16:0]        sc;
    logic signed [31:0] target;
    logic signed [31:0] value;
    logic [16:0]        bc;
  } psb_row_t;

  localparam int unsigned ROW_W = $bits(psb_row_t);

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic rd;
    logic load;
    logic pwr_step;
    logic mul;
    logic upd;
    logic nrm_init;
    logic div_step;
    logic out_load;
  } psb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_pwr;
    logic pwr_last;
    logic sweep_active;
    logic nrm_direct;
    logic div_last;
    logic out_free;
  } psb_sts_t;

  // below low gives low, else above high gives high
  function automatic logic signed [31:0] clamp_q16(logic signed [35:0] v,
                                                   logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/psb_if.sv =====
// Channel interfaces of the parameter smoother bank: item in, result out.
// Stand-alone; no package dependency.
interface psb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [5:0]         entry_index;
  logic signed [31:0] data_value;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic [16:0]        smoothing_coeff;
  logic [15:0]        frame_count;

  modport source(output valid, mode, entry_index, data_value, lower_bound,
                 upper_bound, smoothing_coeff, frame_count, input ready);
  modport sink(input valid, mode, entry_index, data_value, lower_bound,
               upper_bound, smoothing_coeff, frame_count, output ready);
endinterface

interface psb_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] target_out;
  logic signed [31:0] current_out;
  logic [16:0]        normalised_out;

  modport source(output valid, status, target_out, current_out, normalised_out,
                 input ready);
  modport sink(input valid, status, target_out, current_out, normalised_out,
               output ready);
endinterface

// ===== rtl/core/parameter_smoother_bank.sv =====
// Top level of the parameter smoother bank: sequencer plus datapath.
// Depends on psb_pkg, psb_if, psb_ram, psb_ctrl, psb_datapath.
//
//   channel   dir  payload                                              handshake
//   in_i      in   mode, entry_index, data_value, bounds, coeff, frames valid/ready
//   out_o     out  status, target_out, current_out, normalised_out      valid/ready
//
// One item at a time; a single-entry item goes from its transfer to its result
// through RAM read, multiply, update and a 16-step quotient for the normalized
// value, and the next transfer can come in the cycle after the result is loaded.
// Snap-all and advance with a nonzero frame count walk every entry through the
// one RAM port, with up to 16 power steps per entry when the frame count changes.
// Reset clears valid bits, cached frame count and the handshakes; no RAM clear.
// The next item is taken while a result waits in the output register.
module parameter_smoother_bank #(
  parameter int unsigned ENTRIES = psb_pkg::ENTRIES_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psb_in_if.sink    in_i,
  psb_out_if.source out_o
);

  psb_pkg::psb_cmd_t cmd;
  psb_pkg::psb_sts_t sts;
  logic              in_ready;

  assign in_i.ready = in_ready;

  psb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psb_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (in_i.mode),
    .entry_index_i     (in_i.entry_index),
    .data_value_i      (in_i.data_value),
    .lower_bound_i     (in_i.lower_bound),
    .upper_bound_i     (in_i.upper_bound),
    .smoothing_coeff_i (in_i.smoothing_coeff),
    .frame_count_i     (in_i.frame_count),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .status_o          (out_o.status),
    .target_out_o      (out_o.target_out),
    .current_out_o     (out_o.current_out),
    .normalised_out_o  (out_o.normalised_out)
  );

endmodule

// ===== rtl/core/psb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/psb_ctrl.sv =====
// Sequencer of the parameter smoother bank: steps one item through read,
// power, multiply, update and normalize. Uses psb_pkg types.
module psb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  psb_pkg::psb_sts_t sts_i,
  output psb_pkg::psb_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_LD   = 4'd2;
  localparam logic [3:0] S_PWR  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_NRM  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LD;
      end
      S_LD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.need_pwr ? S_PWR : S_MUL;
      end
      S_PWR: begin
        cmd_o.pwr_step = 1'b1;
        if (sts_i.pwr_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.sweep_active ? S_RD : S_NRM;
      end
      S_NRM: begin
        cmd_o.nrm_init = 1'b1;
        state_d        = sts_i.nrm_direct ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/psb_datapath.sv =====
// Datapath of the parameter smoother bank: entry RAM, valid bits, shared
// multiplier, power unit, divider and output register. Uses psb_pkg, psb_ram.
module psb_datapath #(
  parameter int unsigned ENTRIES = psb_pkg::ENTRIES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psb_pkg::psb_cmd_t  cmd_i,
  output psb_pkg::psb_sts_t  sts_o,
  input  logic [2:0]         mode_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [31:0] data_value_i,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  input  logic [16:0]        smoothing_coeff_i,
  input  logic [15:0]        frame_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic signed [31:0] target_out_o,
  output logic signed [31:0] current_out_o,
  output logic [16:0]        normalised_out_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  // captured item
  logic [2:0]         mode_q;
  logic [5:0]         ent_q;
  logic signed [31:0] data_q, lb_q, ub_q;
  logic [16:0]        c_q;
  logic [15:0]        n_q;

  // control state
  logic               sweep_q, recomp_q;
  logic [15:0]        cached_q;
  logic [AW-1:0]      idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic               ok_q;
  logic               out_valid_q;
  logic [3:0]         cnt_q;

  // working registers
  psb_pkg::psb_row_t  row_q, row_new, rdata, row_ld;
  logic [psb_pkg::ROW_W-1:0] rdata_raw;
  logic [16:0]        r_q, b_q;
  logic [15:0]        nsh_q;
  logic signed [50:0] prod_q;
  logic [32:0]        span_q;
  logic [33:0]        rem_q;
  logic [15:0]        quo_q;
  logic [16:0]        norm_q;

  logic               in_range, cur_valid, row_we, pwr_cond;
  logic [AW-1:0]      ent_addr, addr;
  logic signed [32:0] mul_a;
  logic [16:0]        mul_b, t_sat;
  logic signed [34:0] prod_sh;
  logic [33:0]        r_prod, b_prod;
  logic [16:0]        r_next;
  logic signed [32:0] span_w, num_w;
  logic [33:0]        rem2;
  logic               div_ge;

  assign in_range  = (32'(ent_q) < ENTRIES);
  assign ent_addr  = AW'(ent_q);
  assign addr      = sweep_q ? idx_q : ent_addr;
  assign cur_valid = sweep_q ? valid_q[idx_q] : (in_range && valid_q[ent_addr]);
  assign rdata     = psb_pkg::psb_row_t'(rdata_raw);
  assign pwr_cond  = sweep_q && (mode_q == psb_pkg::MODE_ADVANCE) && recomp_q &&
                     valid_q[idx_q];

  psb_ram #(
    .WIDTH (psb_pkg::ROW_W),
    .DEPTH (ENTRIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (addr),
    .wdata_i (row_new),
    .re_i    (cmd_i.rd),
    .raddr_i (addr),
    .rdata_o (rdata_raw)
  );

  // row as loaded: force the block coefficient to one when no smoothing
  always_comb begin
    row_ld = rdata;
    if (pwr_cond && (rdata.sc >= psb_pkg::ONE_Q16)) begin
      row_ld.bc = psb_pkg::ONE_Q16;
    end
  end

  // normalized amount limited to 0..1
  always_comb begin
    if (data_q < 0) begin
      t_sat = '0;
    end else if (data_q > $signed({15'd0, psb_pkg::ONE_Q16})) begin
      t_sat = psb_pkg::ONE_Q16;
    end else begin
      t_sat = data_q[16:0];
    end
  end

  // shared multiplier operands: step of advance or span scaling
  assign mul_a = sweep_q ? ($signed({row_q.target[31], row_q.target}) -
                            $signed({row_q.value[31], row_q.value}))
                         : ($signed({row_q.high[31], row_q.high}) -
                            $signed({row_q.low[31], row_q.low}));
  assign mul_b   = sweep_q ? row_q.bc : t_sat;
  assign prod_sh = $signed(prod_q[50:16]);

  // power unit: one bit of N per cycle
  assign r_prod = r_q * b_q;
  assign b_prod = b_q * b_q;
  assign r_next = nsh_q[0] ? r_prod[32:16] : r_q;

  // new row contents for the update cycle
  always_comb begin
    logic signed [35:0] sum;
    row_new = row_q;
    row_we  = 1'b0;
    sum     = $signed({{4{row_q.low[31]}}, row_q.low}) +
              $signed({prod_sh[34], prod_sh});
    if (sweep_q) begin
      if (cur_valid) begin
        row_we = cmd_i.upd;
        if (mode_q == psb_pkg::MODE_SNAP_ALL) begin
          row_new.value = row_q.target;
        end else begin
          sum = $signed({{4{row_q.value[31]}}, row_q.value}) +
                $signed({prod_sh[34], prod_sh});
          row_new.value = sum[31:0];
        end
      end
    end else begin
      case (mode_q)
        psb_pkg::MODE_DEFINE: begin
          if (in_range) begin
            row_we      = cmd_i.upd;
            row_new.low  = lb_q;
            row_new.high = ub_q;
            row_new.sc   = (c_q > psb_pkg::ONE_Q16) ? psb_pkg::ONE_Q16 : c_q;
            row_new.bc   = row_new.sc;
            row_new.target = psb_pkg::clamp_q16({{4{data_q[31]}}, data_q}, lb_q, ub_q);
            row_new.value  = row_new.target;
          end
        end
        psb_pkg::MODE_SET: begin
          row_we = cmd_i.upd && cur_valid;
          row_new.target = psb_pkg::clamp_q16({{4{data_q[31]}}, data_q},
                                              row_q.low, row_q.high);
        end
        psb_pkg::MODE_SET_NORM: begin
          row_we = cmd_i.upd && cur_valid;
          row_new.target = psb_pkg::clamp_q16(sum, row_q.low, row_q.high);
        end
        psb_pkg::MODE_SNAP: begin
          row_we = cmd_i.upd && cur_valid;
          row_new.value = row_q.target;
        end
        default: begin
          row_we = 1'b0;
        end
      endcase
    end
  end

  // normalization operands and divider step
  assign span_w = $signed({row_q.high[31], row_q.high}) - $signed({row_q.low[31], row_q.low});
  assign num_w  = $signed({row_q.value[31], row_q.value}) - $signed({row_q.low[31], row_q.low});
  assign rem2   = {rem_q[32:0], 1'b0};
  assign div_ge = (rem2 >= {1'b0, span_q});

  // status to the sequencer
  always_comb begin
    sts_o.need_pwr     = pwr_cond && (rdata.sc < psb_pkg::ONE_Q16);
    sts_o.pwr_last     = (nsh_q[15:1] == '0);
    sts_o.sweep_active = sweep_q;
    sts_o.nrm_direct   = !ok_q || (span_w <= 0) || (num_w <= 0) || (num_w >= span_w);
    sts_o.div_last     = (cnt_q == 4'd15);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b0;
      recomp_q    <= 1'b0;
      cached_q    <= '0;
      idx_q       <= '0;
      valid_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.cap) begin
        idx_q    <= '0;
        sweep_q  <= (mode_i == psb_pkg::MODE_SNAP_ALL) ||
                    ((mode_i == psb_pkg::MODE_ADVANCE) && (frame_count_i != '0));
        recomp_q <= (mode_i == psb_pkg::MODE_ADVANCE) && (frame_count_i != '0) &&
                    (frame_count_i != cached_q);
        if ((mode_i == psb_pkg::MODE_ADVANCE) && (frame_count_i != '0)) begin
          cached_q <= frame_count_i;
        end
      end
      if (cmd_i.upd) begin
        if (sweep_q) begin
          // advance the sweep and re-read the next entry, or end it after the last entry
          if (idx_q == LAST_IDX) begin
            sweep_q <= 1'b0;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end else begin
          ok_q <= in_range && (cur_valid || (mode_q == psb_pkg::MODE_DEFINE));
          if ((mode_q == psb_pkg::MODE_DEFINE) && in_range) begin
            valid_q[ent_addr] <= 1'b1;
          end
        end
      end
      if (cmd_i.nrm_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_i;
      ent_q  <= entry_index_i;
      data_q <= data_value_i;
      lb_q   <= lower_bound_i;
      ub_q   <= upper_bound_i;
      c_q    <= smoothing_coeff_i;
      n_q    <= frame_count_i;
    end
    if (cmd_i.load) begin
      row_q <= row_ld;
      r_q   <= psb_pkg::ONE_Q16;
      b_q   <= psb_pkg::ONE_Q16 - rdata.sc;
      nsh_q <= n_q;
    end
    if (cmd_i.pwr_step) begin
      r_q   <= r_next;
      b_q   <= b_prod[32:16];
      nsh_q <= {1'b0, nsh_q[15:1]};
      if (nsh_q[15:1] == '0) begin
        row_q.bc <= psb_pkg::ONE_Q16 - r_next;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * $signed({1'b0, mul_b});
    end
    if (cmd_i.upd) begin
      row_q <= row_new;
    end
    // set up the quotient or the direct result
    if (cmd_i.nrm_init) begin
      span_q <= span_w;
      rem_q  <= {1'b0, num_w};
      quo_q  <= '0;
      if (!ok_q || (span_w <= 0) || (num_w <= 0)) begin
        norm_q <= '0;
      end else begin
        norm_q <= psb_pkg::ONE_Q16;
      end
    end
    if (cmd_i.div_step) begin
      rem_q  <= div_ge ? (rem2 - {1'b0, span_q}) : rem2;
      quo_q  <= {quo_q[14:0], div_ge};
      norm_q <= {1'b0, quo_q[14:0], div_ge};
    end
    if (cmd_i.out_load) begin
      status_o         <= !ok_q;
      target_out_o     <= ok_q ? row_q.target : '0;
      current_out_o    <= ok_q ? row_q.value : '0;
      normalised_out_o <= ok_q ? norm_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && sweep_q && (idx_q == LAST_IDX) |=> !sweep_q)
    else $error("sweep did not end after last entry");
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while waiting");
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < {1'b0, span_q}))
    else $error("divider remainder not below span");
  a_bc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pwr_step && (nsh_q[15:1] == '0) |=> (row_q.bc <= psb_pkg::ONE_Q16))
    else $error("block coefficient above one");

endmodule
